>>> rtl/core/fmd_pkg.sv
// Shared types and constants of the framed message deframer.
package fmd_pkg;

   // Result kinds carried on the result channel's tuser.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_TOO_BIG = 2'd2;

   // Configuration register indexes.
   localparam logic [0:0] CSR_MAGIC_FIRST  = 1'b0;
   localparam logic [0:0] CSR_MAGIC_SECOND = 1'b1;

   // Widths of the channel fields.
   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 10;
   localparam int LEN_W       = 32;
   localparam int RSP_DATA_W  = 40;

   // One result item as it travels from the parser to the output buffer.
   typedef struct packed {
      logic [1:0]         kind;
      logic [BYTE_W-1:0]  msg_type;
      logic [BYTE_W-1:0]  seq_no;
      logic [BYTE_W-1:0]  data_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               is_last;
   } rsp_type;

endpackage

>>> rtl/core/fmd_parser.sv
// Frame parser: magic hunt, header capture, length assembly and payload tagging.
module fmd_parser #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [0:0]              csr_index,
   input  logic [fmd_pkg::BYTE_W-1:0] csr_data,
   input  logic                    byte_accept,
   input  logic [fmd_pkg::BYTE_W-1:0] rx_byte,
   output logic                    rsp_push,
   output fmd_pkg::rsp_type        rsp_item
);
   import fmd_pkg::*;

   localparam int CNT_RAW = $clog2(MAX_PAYLOAD + 1);
   localparam int CNT_W   = (CNT_RAW < 2) ? 2 : CNT_RAW;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_MAGIC = 3'd1,
      PH_TYPE  = 3'd2,
      PH_SEQ   = 3'd3,
      PH_LEN   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               rev_ff, rev_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BYTE_W-1:0]  type_ff, type_in;
   logic [BYTE_W-1:0]  seq_ff, seq_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]  magic_first_ff, magic_second_ff;

   logic [1:0]         len_slot;
   logic [LEN_W-1:0]   len_full;
   logic [LEN_W:0]     idx_next;
   logic [LEN_W-1:0]   idx_wide;
   logic               data_last;

   // Length byte placement and payload position helpers.
   always_comb begin
      len_slot = rev_ff ? (2'd3 - cnt_ff[1:0]) : cnt_ff[1:0];
      len_full = len_ff | (LEN_W'(rx_byte) << {len_slot, 3'd0});
      idx_wide = LEN_W'(cnt_ff);
      idx_next = {1'b0, idx_wide} + (LEN_W + 1)'(1);
      data_last = idx_next >= {1'b0, len_ff};
   end

   // Next state and the result that this byte gives, if any.
   always_comb begin
      phase_in = phase_ff;
      rev_in   = rev_ff;
      cnt_in   = cnt_ff;
      type_in  = type_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      rsp_push = 1'b0;
      rsp_item.kind       = KIND_PAYLOAD;
      rsp_item.msg_type   = type_ff;
      rsp_item.seq_no     = seq_ff;
      rsp_item.data_byte  = '0;
      rsp_item.byte_index = '0;
      rsp_item.is_last    = 1'b1;
      unique case (phase_ff)
         PH_MAGIC: begin
            if (rev_ff ? (rx_byte == magic_second_ff) : (rx_byte == magic_first_ff)) begin
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_TYPE: begin
            type_in  = rx_byte;
            phase_in = PH_SEQ;
         end
         PH_SEQ: begin
            seq_in   = rx_byte;
            cnt_in   = '0;
            len_in   = '0;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in = len_full;
            if (cnt_ff[1:0] != 2'd3) begin
               cnt_in = CNT_W'(cnt_ff[1:0]) + CNT_W'(1);
            end else begin
               cnt_in = '0;
               if (len_full == '0) begin
                  phase_in      = PH_HUNT;
                  rsp_push      = 1'b1;
                  rsp_item.kind = KIND_EMPTY;
               end else if ({1'b0, len_full} > (LEN_W + 1)'(MAX_PAYLOAD)) begin
                  phase_in      = PH_HUNT;
                  rsp_push      = 1'b1;
                  rsp_item.kind = KIND_TOO_BIG;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            rsp_push            = 1'b1;
            rsp_item.kind       = KIND_PAYLOAD;
            rsp_item.data_byte  = rx_byte;
            rsp_item.byte_index = idx_wide[INDEX_W-1:0];
            rsp_item.is_last    = data_last;
            if (data_last) begin
               phase_in = PH_HUNT;
               cnt_in   = '0;
            end else begin
               cnt_in = idx_next[CNT_W-1:0];
            end
         end
         default: begin
            // Hunting; a byte matching both magic registers picks reversed order.
            if (rx_byte == magic_first_ff) begin
               rev_in   = 1'b1;
               phase_in = PH_MAGIC;
            end else if (rx_byte == magic_second_ff) begin
               rev_in   = 1'b0;
               phase_in = PH_MAGIC;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   // Parse state and magic registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         rev_ff          <= 1'b0;
         cnt_ff          <= '0;
         type_ff         <= '0;
         seq_ff          <= '0;
         len_ff          <= '0;
         magic_first_ff  <= '0;
         magic_second_ff <= '0;
      end else begin
         if (byte_accept) begin
            phase_ff <= phase_in;
            rev_ff   <= rev_in;
            cnt_ff   <= cnt_in;
            type_ff  <= type_in;
            seq_ff   <= seq_in;
            len_ff   <= len_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_MAGIC_FIRST:  magic_first_ff  <= csr_data;
               CSR_MAGIC_SECOND: magic_second_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

>>> rtl/core/fmd_rsp_buf.sv
// Result register and one skid entry; a stalled output stops intake once both are held.
module fmd_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fmd_pkg::rsp_type push_item,
   output logic             can_push,
   output logic             out_valid,
   input  logic             out_ready,
   output fmd_pkg::rsp_type out_item
);
   import fmd_pkg::*;

   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff;
   logic    pop;

   assign pop       = out_valid_ff & out_ready;
   assign can_push  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

   // Control: the skid entry fills only when the output register is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload moves.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= push_item;
         end else begin
            out_ff <= push_item;
         end
      end
   end

endmodule

>>> rtl/core/framed_message_deframer_unit.sv
// Top level of the framed message deframer.
// Takes one received byte per cycle and emits at most one result per byte; a byte is
// handled in the cycle it is accepted and its result is registered in the output
// register, or in the skid entry when that is stalled. With these two entries,
// intake continues at one byte per cycle while results are taken each cycle and
// pauses only once both entries are held by a stalled result channel.
// The frame is: two magic bytes (their arrival order selects byte order), a type
// byte, a sequence byte, a 4-byte length, then the payload. A zero length gives one
// empty-message result, a length above MAX_PAYLOAD gives one error result; both end
// the frame. The user must write magic registers via csr only while idle (unchecked).
module framed_message_deframer_unit #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data,
   // Byte request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] msg_type, [15:8] seq_no, [23:16] data_byte,
                                    // [33:24] byte_index, [39:34] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // is_last
);
   import fmd_pkg::*;

   logic    byte_accept;
   logic    rsp_push;
   logic    can_push;
   rsp_type push_item;
   rsp_type out_item;

   assign csr_ready   = 1'b1;
   assign req_tready  = can_push;
   assign byte_accept = req_tvalid & can_push;

   fmd_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .rsp_push    (rsp_push),
      .rsp_item    (push_item)
   );

   fmd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_accept & rsp_push),
      .push_item (push_item),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // Pack the result onto the stream fields.
   assign rsp_tdata = {6'd0, out_item.byte_index, out_item.data_byte,
                       out_item.seq_no, out_item.msg_type};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.is_last;

endmodule

>>> dv/framed_message_deframer_checker.sv
// Checker of the framed message deframer: predicts results from accepted requests and compares.
`timescale 1ns / 100ps

module framed_message_deframer_checker #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);
   import fmd_pkg::*;

   // Which part of the frame the parser expects next.
   typedef enum logic [2:0] {
      HUNT_FIRST    = 3'd0,
      EXPECT_SECOND = 3'd1,
      TAKE_TYPE     = 3'd2,
      TAKE_SEQ      = 3'd3,
      TAKE_LENGTH   = 3'd4,
      TAKE_PAYLOAD  = 3'd5
   } parse_phase_type;

   // Predicted parser state and register copies.
   parse_phase_type phase;
   logic [7:0]   magic_rev_lead;
   logic [7:0]   magic_norm_lead;
   logic         frame_reversed;
   int           position;
   logic [7:0]   frame_type;
   logic [7:0]   frame_seq;
   logic [31:0]  frame_length;

   rsp_type      expected_results[$];
   int           mismatches = 0;
   int           results_due = 0;

   assign fail_count = mismatches;
   assign pending    = results_due;

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Advances the predicted parser by one received byte and queues any result it causes.
   task automatic parse_byte(input logic [7:0] rx);
      rsp_type     res;
      logic [1:0]  lane_no;
      logic [31:0] lane;
      bit          produces;
      res      = '0;
      produces = 1'b0;
      case (phase)
         EXPECT_SECOND: begin
            if (rx == (frame_reversed ? magic_norm_lead : magic_rev_lead)) begin
               phase = TAKE_TYPE;
            end else begin
               phase = HUNT_FIRST;
            end
         end
         TAKE_TYPE: begin
            frame_type = rx;
            phase      = TAKE_SEQ;
         end
         TAKE_SEQ: begin
            frame_seq    = rx;
            position     = 0;
            frame_length = '0;
            phase        = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            // Length bytes land low first in normal order, high first in reversed order.
            lane_no = position[1:0];
            lane    = {24'd0, rx};
            frame_length |= frame_reversed ? (lane << (8 * (3 - lane_no)))
                                           : (lane << (8 * lane_no));
            position = lane_no + 1;
            if (position == 4) begin
               position = 0;
               if (frame_length == 0) begin
                  produces    = 1'b1;
                  res.kind    = KIND_EMPTY;
                  res.is_last = 1'b1;
                  phase       = HUNT_FIRST;
               end else if (frame_length > MAX_PAYLOAD) begin
                  produces    = 1'b1;
                  res.kind    = KIND_TOO_BIG;
                  res.is_last = 1'b1;
                  phase       = HUNT_FIRST;
               end else begin
                  phase = TAKE_PAYLOAD;
               end
            end
         end
         TAKE_PAYLOAD: begin
            produces       = 1'b1;
            res.kind       = KIND_PAYLOAD;
            res.data_byte  = rx;
            res.byte_index = position[INDEX_W-1:0];
            res.is_last    = (position + 1 >= frame_length);
            position++;
            if (res.is_last) begin
               phase    = HUNT_FIRST;
               position = 0;
            end
         end
         default: begin
            // A byte matching both magic registers selects reversed order.
            if (rx == magic_rev_lead) begin
               frame_reversed = 1'b1;
               phase          = EXPECT_SECOND;
            end else if (rx == magic_norm_lead) begin
               frame_reversed = 1'b0;
               phase          = EXPECT_SECOND;
            end else begin
               phase = HUNT_FIRST;
            end
         end
      endcase
      if (produces) begin
         res.msg_type = frame_type;
         res.seq_no   = frame_seq;
         expected_results.push_back(res);
      end
   endtask

   // Compares one accepted result with the oldest expectation.
   task automatic check_result();
      rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing expected (kind)", rsp_tuser, 0);
      end else begin
         want = expected_results.pop_front();
         if (rsp_tuser !== want.kind) report_mismatch("kind", rsp_tuser, want.kind);
         if (rsp_tdata[7:0] !== want.msg_type)
            report_mismatch("msg_type", rsp_tdata[7:0], want.msg_type);
         if (rsp_tdata[15:8] !== want.seq_no)
            report_mismatch("seq_no", rsp_tdata[15:8], want.seq_no);
         if (rsp_tdata[23:16] !== want.data_byte)
            report_mismatch("data_byte", rsp_tdata[23:16], want.data_byte);
         if (rsp_tdata[33:24] !== want.byte_index)
            report_mismatch("byte_index", rsp_tdata[33:24], want.byte_index);
         if (rsp_tdata[39:34] !== 6'd0)
            report_mismatch("tdata padding", rsp_tdata[39:34], 0);
         if (rsp_tlast !== want.is_last)
            report_mismatch("is_last", rsp_tlast, want.is_last);
      end
   endtask

   // Watch all three channels at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         phase           = HUNT_FIRST;
         magic_rev_lead  = '0;
         magic_norm_lead = '0;
         frame_reversed  = 1'b0;
         position        = 0;
         frame_type      = '0;
         frame_seq       = '0;
         frame_length    = '0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) check_result();
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            if (csr_index == CSR_MAGIC_FIRST) begin
               magic_rev_lead = csr_data;
            end else begin
               magic_norm_lead = csr_data;
            end
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1) parse_byte(req_tdata);
      end
      results_due = expected_results.size();
   end

endmodule

>>> dv/framed_message_deframer_unit_tb.sv
// Testbench top of the framed message deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module framed_message_deframer_unit_tb;
   import fmd_pkg::*;

   localparam int MAX_LEN      = 1024;
   localparam int PHASE_ITEMS  = 215;
   localparam int LONG_HOLD    = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_MAGIC_FIRST;
   logic [7:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;

   // Stimulus state shared by the sender and the receiver.
   bit          idle_enabled = 1'b1;
   int          hold_requests = 0;
   int          sent_count = 0;
   logic [7:0]  cur_first = '0;
   logic [7:0]  cur_second = '0;

   always #10 clock = ~clock;

   framed_message_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   framed_message_deframer_checker #(.MAX_PAYLOAD(MAX_LEN)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Receiver: random stall bursts, plus one long hold-off whenever the sender asks.
   initial begin
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one received byte and waits for its request to be accepted.
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      if (idle_enabled && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
      sent_count++;
   endtask

   // Sends a complete frame; the payload follows only for a length the block accepts.
   task automatic send_frame(input bit reversed, input logic [7:0] msg_type,
                             input logic [7:0] seq_no, input logic [31:0] length);
      int idx;
      send_byte(reversed ? cur_first : cur_second);
      send_byte(reversed ? cur_second : cur_first);
      send_byte(msg_type);
      send_byte(seq_no);
      for (idx = 0; idx < 4; idx++) begin
         send_byte(reversed ? length[8 * (3 - idx) +: 8] : length[8 * idx +: 8]);
      end
      if (length != 0 && length <= MAX_LEN) begin
         for (idx = 0; idx < length; idx++) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Mostly well-formed frames with random content, some noise and broken magic words.
   task automatic send_random_traffic();
      int          pick;
      int          idx;
      bit          reversed;
      logic [31:0] length;
      pick = $urandom_range(0, 19);
      // With equal magic bytes the hunt always picks reversed order.
      reversed = (cur_first == cur_second) ? 1'b1 : 1'($urandom_range(0, 1));
      if (pick < 14) begin
         case ($urandom_range(0, 19))
            0:       length = 32'd0;
            1:       length = 32'd1025;
            2:       length = 32'hFFFF_FFFF;
            3:       length = $urandom | 32'h0000_0800;
            4, 5:    length = $urandom_range(17, 64);
            default: length = $urandom_range(1, 16);
         endcase
         send_frame(reversed, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    length);
      end else if (pick < 17) begin
         for (idx = $urandom_range(1, 6); idx > 0; idx--) begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end else begin
         // Lead magic byte followed by a wrong second byte.
         send_byte(reversed ? cur_first : cur_second);
         send_byte((reversed ? cur_second : cur_first) ^ 8'($urandom_range(1, 255)));
      end
   endtask

   // Writes both magic registers over the configuration channel.
   task automatic set_magic(input logic [7:0] first_val, input logic [7:0] second_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_MAGIC_FIRST;
      csr_data  <= first_val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_index <= CSR_MAGIC_SECOND;
      csr_data  <= second_val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid  <= 1'b0;
      cur_first  = first_val;
      cur_second = second_val;
   endtask

   // Waits until every expected result has arrived and the parser has settled.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Main stimulus.
   initial begin
      int budget_end;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames: empty message, wrong second magic, oversize length, one-byte payload.
      set_magic(8'hA5, 8'h5A);
      send_frame(1'b0, 8'h00, 8'hFF, 32'd0);
      send_byte(8'h5A);
      send_byte(8'h5A);
      send_frame(1'b1, 8'hFF, 8'h00, 32'd1025);
      send_frame(1'b1, 8'h80, 8'h7F, 32'd1);

      // The receiver holds off while a longer frame keeps coming.
      hold_requests++;
      send_frame(1'b0, 8'h11, 8'h22, 32'd40);
      budget_end = sent_count + PHASE_ITEMS;
      while (sent_count < budget_end) send_random_traffic();

      // Equal magic bytes at the low extreme.
      wait_idle();
      set_magic(8'h00, 8'h00);
      budget_end = sent_count + PHASE_ITEMS;
      while (sent_count < budget_end) send_random_traffic();

      wait_idle();
      set_magic(8'hFF, 8'h00);
      budget_end = sent_count + PHASE_ITEMS;
      while (sent_count < budget_end) send_random_traffic();

      // Last stretch without idling.
      wait_idle();
      idle_enabled = 1'b0;
      set_magic(8'h3C, 8'hFF);
      budget_end = sent_count + PHASE_ITEMS;
      while (sent_count < budget_end) send_random_traffic();

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS framed_message_deframer_unit");
      end else begin
         $display("FAIL framed_message_deframer_unit");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #10_000_000;
      $display("FAIL framed_message_deframer_unit");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/fmd_pkg.sv
rtl/core/fmd_parser.sv
rtl/core/fmd_rsp_buf.sv
rtl/core/framed_message_deframer_unit.sv
dv/framed_message_deframer_checker.sv
dv/framed_message_deframer_unit_tb.sv
